// ----- rtl/sfpc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpc_pkg
// Types, codes and helpers shared by the seeded Fletcher packet checker.
// ----------------------------------------------------------------------------
package sfpc_pkg;

    localparam int HDR_LEN     = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] ASCII_ZERO_NEG = 8'd207;  // 255 - '0'
    localparam logic [7:0] ASCII_NL       = 8'h0A;
    localparam logic [7:0] ASCII_N        = 8'h6E;
    localparam logic [7:0] MINUS_ONE_255  = 8'd254;

    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_HDR  = 2'd0;
    localparam cmd_kind_t CMD_PAY  = 2'd1;
    localparam cmd_kind_t CMD_NL   = 2'd2;
    localparam cmd_kind_t CMD_MALF = 2'd3;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        first_pay;
        logic [2:0]  hpos;
        logic [7:0]  data;
        logic [31:0] exp_seq;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [31:0] received_seq;
        logic [15:0] computed_checksum;
        logic        malformed;
        logic        ack_accepted;
        logic        is_nack;
        logic        seq_match;
        logic        checksum_ok;
    } result_t;

    // (a + b) mod 255 for a, b in 0..254
    function automatic logic [7:0] add255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        logic [8:0] d;
        begin
            s = {1'b0, a} + {1'b0, b};
            d = s - 9'd255;
            add255 = (s >= 9'd255) ? d[7:0] : s[7:0];
        end
    endfunction

endpackage

// ----- rtl/sfpc_front.sv -----
// ----------------------------------------------------------------------------
// sfpc_front
// Tracks byte position and termination, classifies each byte it does not drop into a command.
// ----------------------------------------------------------------------------
module sfpc_front #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // data_byte[7:0], expected_seq[39:8]
    input  logic                s_tlast,   // last_byte
    input  sfpc_pkg::q_status_t q_status,
    output logic                push,
    output sfpc_pkg::cmd_t      cmd
);
    import sfpc_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             term_reg, term_next;
    logic             accept;
    logic [7:0]       data_byte;
    logic             in_header;

    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign data_byte = s_tdata[7:0];
    assign in_header = pos_reg < POS_W'(HDR_LEN);

    always_comb
    begin
        pos_next      = pos_reg;
        term_next     = term_reg;
        push          = 1'b0;
        cmd.kind      = CMD_MALF;
        cmd.first_pay = (pos_reg == POS_W'(HDR_LEN));
        cmd.hpos      = pos_reg[2:0];
        cmd.data      = data_byte;
        cmd.exp_seq   = s_tdata[39:8];
        if (accept)
        begin
            if (term_reg)
            begin
                // drop trailing bytes until the end of the datagram
                if (s_tlast)
                begin
                    pos_next  = '0;
                    term_next = 1'b0;
                end
            end
            else if (pos_reg >= POS_W'(MAX_PACKET_BYTES) ||
                     (!in_header && data_byte == ASCII_NL))
            begin
                push     = 1'b1;
                cmd.kind = (pos_reg >= POS_W'(MAX_PACKET_BYTES)) ? CMD_MALF : CMD_NL;
                if (s_tlast)
                begin
                    pos_next = '0;
                end
                else
                begin
                    term_next = 1'b1;
                end
            end
            else
            begin
                push = 1'b1;
                if (s_tlast)
                begin
                    cmd.kind = CMD_MALF;
                    pos_next = '0;
                end
                else
                begin
                    cmd.kind = in_header ? CMD_HDR : CMD_PAY;
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            term_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            term_reg <= term_next;
        end
    end

endmodule

// ----- rtl/sfpc_queue.sv -----
// ----------------------------------------------------------------------------
// sfpc_queue
// Short command queue between the classifier and the checksum engine.
// ----------------------------------------------------------------------------
module sfpc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sfpc_pkg::cmd_t      wr_cmd,
    input  logic                pop,
    output sfpc_pkg::cmd_t      rd_cmd,
    output sfpc_pkg::q_status_t status
);
    import sfpc_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign rd_cmd       = mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/sfpc_back.sv -----
// ----------------------------------------------------------------------------
// sfpc_back
// Collects header fields, runs the seeded mod-255 sums, registers results.
// ----------------------------------------------------------------------------
module sfpc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sfpc_pkg::q_status_t q_status,
    input  sfpc_pkg::cmd_t      cmd,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata    // checksum_ok, seq_match, is_nack, ack_accepted,
                                           // malformed, computed_checksum[20:5],
                                           // received_seq[52:21], zero pad
);
    import sfpc_pkg::*;

    logic [31:0] cks_reg, cks_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] exp_reg, exp_next;
    logic [7:0]  seed_reg, seed_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic        nack_reg, nack_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic [7:0]  seed_sum;
    logic [7:0]  pay_term;
    logic [15:0] cs;
    logic        ck;
    logic        sm;

    assign pop      = !q_status.empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign seed_sum = add255(seed_reg, cmd.data);
    assign pay_term = add255(cmd.data, ASCII_ZERO_NEG);
    assign cs       = {second_reg, first_reg};
    assign ck       = ({16'd0, cs} == cks_reg);
    assign sm       = (seq_reg == exp_reg);

    always_comb
    begin
        cks_next       = cks_reg;
        seq_next       = seq_reg;
        exp_next       = exp_reg;
        seed_next      = seed_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        nack_next      = nack_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            case (cmd.kind)
                CMD_HDR:
                begin
                    case (cmd.hpos)
                        3'd0:
                        begin
                            // datagram start: load checksum, expected seq; clear nack
                            cks_next  = {24'd0, cmd.data};
                            exp_next  = cmd.exp_seq;
                            nack_next = 1'b0;
                        end
                        3'd1: cks_next[15:8]  = cmd.data;
                        3'd2: cks_next[23:16] = cmd.data;
                        3'd3: cks_next[31:24] = cmd.data;
                        3'd4:
                        begin
                            seq_next  = {24'd0, cmd.data};
                            seed_next = add255(8'd0, cmd.data);
                        end
                        3'd5:
                        begin
                            seq_next[15:8] = cmd.data;
                            seed_next      = seed_sum;
                        end
                        3'd6:
                        begin
                            seq_next[23:16] = cmd.data;
                            seed_next       = seed_sum;
                        end
                        default:
                        begin
                            seq_next[31:24] = cmd.data;
                            // negative sequence: 2^32 is 1 mod 255, so take one off
                            first_next  = cmd.data[7] ? add255(seed_sum, MINUS_ONE_255)
                                                      : seed_sum;
                            second_next = first_next;
                        end
                    endcase
                end
                CMD_PAY:
                begin
                    if (cmd.first_pay)
                    begin
                        nack_next = (cmd.data == ASCII_N);
                    end
                    first_next  = add255(first_reg, pay_term);
                    second_next = add255(second_reg, first_next);
                end
                CMD_NL:
                begin
                    out_valid_next             = 1'b1;
                    out_next.pad               = '0;
                    out_next.checksum_ok       = ck;
                    out_next.seq_match         = sm;
                    out_next.is_nack           = nack_reg;
                    out_next.ack_accepted      = ck && sm && !nack_reg;
                    out_next.malformed         = 1'b0;
                    out_next.computed_checksum = cs;
                    out_next.received_seq      = seq_reg;
                end
                default:
                begin
                    out_valid_next     = 1'b1;
                    out_next           = '0;
                    out_next.malformed = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cks_reg    <= cks_next;
        seq_reg    <= seq_next;
        exp_reg    <= exp_next;
        seed_reg   <= seed_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        nack_reg   <= nack_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/seeded_fletcher_packet_checker.sv -----
// ----------------------------------------------------------------------------
// seeded_fletcher_packet_checker
// Byte-serial datagram checker: header capture, seeded Fletcher-16, verdict.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained while the result side keeps up.
// With the queue empty, a byte that ends a packet is written into the four-entry
// command queue and then popped from it into the result register, which drives
// m_tvalid. The queue decouples byte intake from the sum engine; when it is full
// s_tready drops. Reset clears position, queue and result valid at once.
module seeded_fletcher_packet_checker #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], expected_seq[39:8]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // checksum_ok, seq_match, is_nack, ack_accepted,
                                   // malformed, computed_checksum[20:5],
                                   // received_seq[52:21], zero pad
);
    import sfpc_pkg::*;

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      wr_cmd;
    cmd_t      rd_cmd;

    sfpc_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .cmd      (wr_cmd)
    );

    sfpc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (rd_cmd),
        .status (q_status)
    );

    sfpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .cmd      (rd_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("command pushed into full queue");

    a_ack_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[1] && !m_tdata[2] && !m_tdata[4])
        else $error("ack reported without passing checks");

    a_malformed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3:0] == 4'd0 && m_tdata[52:5] == 48'd0)
        else $error("malformed result carries nonzero fields");

endmodule
